// File: rtl/overlay_tint_with_border_top_macros.svh
// Assertion macros shared by the overlay tint blocks.
`ifndef OVERLAY_TINT_WITH_BORDER_TOP_MACROS_SVH
`define OVERLAY_TINT_WITH_BORDER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// A property that must hold at every clock edge outside reset.
`define OTB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must never be seen at a clock edge outside reset.
`define OTB_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define OTB_ASSERT(label, clk, rst_n, prop, msg)
`define OTB_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/otb_pkg.sv
// Types, constants and arithmetic helpers of the overlay tint block.
`default_nettype none

package otb_pkg;

  localparam int PixW   = 8;
  localparam int ColorW = 24;
  localparam int DimW   = 13;
  localparam int QDepth = 2;
  localparam int QPtrW  = 1;
  localparam int QCntW  = 2;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] RegPrimary = 3'd0;
  localparam logic [2:0] RegBorder  = 3'd1;
  localparam logic [2:0] RegEnable  = 3'd2;
  localparam logic [2:0] RegWidth   = 3'd3;
  localparam logic [2:0] RegHeight  = 3'd4;

  typedef struct packed {
    logic [ColorW-1:0] primary_color;
    logic [ColorW-1:0] border_color;
    logic              border_enable;
    logic [DimW-1:0]   image_width;
    logic [DimW-1:0]   image_height;
  } cfg_t;

  // One classified pixel as it waits between front and back.
  typedef struct packed {
    logic [PixW-1:0] luminance;
    logic [PixW-1:0] alpha_in;
    logic            border;
    logic            frame_end;
  } pix_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Exact floor(x/255) for 16-bit x up to 65279, where the quotient fits in 8 bits.
  function automatic logic [PixW-1:0] div255(input logic [15:0] x);
    logic [15:0] s;
    s = x + {8'd0, x[15:8]} + 16'd1;
    return s[15:8];
  endfunction

endpackage

`default_nettype wire

// File: rtl/otb_front.sv
// Front end: accepts pixels, tracks the raster position and marks border pixels.
`default_nettype none

module otb_front #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  otb_pkg::cfg_t       cfg_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,
  input  otb_pkg::q_status_t  q_status_i,
  output logic                push_o,
  output otb_pkg::pix_entry_t entry_o
);
  import otb_pkg::*;

  localparam int CntW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
  localparam int LimW = (CntW + 1 > DimW) ? CntW + 1 : DimW;

  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic [LimW-1:0] width_raw, height_raw, width_sz, height_sz;
  logic [LimW-1:0] last_col_idx, last_row_idx;
  logic            last_col, last_row, on_edge, accept;

  assign width_raw  = LimW'(cfg_i.image_width);
  assign height_raw = LimW'(cfg_i.image_height);

  // Zero sizes count as one, oversize values as the largest supported size.
  always_comb begin
    if (width_raw == '0) begin
      width_sz = LimW'(1);
    end else if (width_raw > LimW'(MAX_DIMENSION)) begin
      width_sz = LimW'(MAX_DIMENSION);
    end else begin
      width_sz = width_raw;
    end
    if (height_raw == '0) begin
      height_sz = LimW'(1);
    end else if (height_raw > LimW'(MAX_DIMENSION)) begin
      height_sz = LimW'(MAX_DIMENSION);
    end else begin
      height_sz = height_raw;
    end
  end

  assign last_col_idx = width_sz - LimW'(1);
  assign last_row_idx = height_sz - LimW'(1);
  // A counter beyond the last index after a size change still counts as last.
  assign last_col = LimW'(col_q) >= last_col_idx;
  assign last_row = LimW'(row_q) >= last_row_idx;
  assign on_edge  = (col_q == '0) || (row_q == '0) || last_col || last_row;

  assign s_axis_tready = !q_status_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_o        = accept;

  always_comb begin
    entry_o.luminance = s_axis_tdata[7:0];
    entry_o.alpha_in  = s_axis_tdata[15:8];
    entry_o.border    = cfg_i.border_enable && on_edge;
    entry_o.frame_end = last_col && last_row;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

`include "overlay_tint_with_border_top_macros.svh"

  `OTB_ASSERT(a_frame_wraps, clk_i, rst_ni, (accept && entry_o.frame_end) |=> (col_q == '0 && row_q == '0), "counters did not wrap after the last pixel of a frame")
  `OTB_ASSERT(a_col_steps, clk_i, rst_ni, (accept && !last_col) |=> (col_q == $past(col_q) + 1'b1), "column counter did not advance by one")

endmodule

`default_nettype wire

// File: rtl/otb_queue.sv
// Two-entry queue that decouples pixel classification from blending.
`default_nettype none

module otb_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  otb_pkg::pix_entry_t push_data_i,
  input  logic                pop_i,
  output otb_pkg::pix_entry_t pop_data_o,
  output otb_pkg::q_status_t  status_o
);
  import otb_pkg::*;

  pix_entry_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;

  assign status_o.full  = count_q == QCntW'(QDepth);
  assign status_o.empty = count_q == '0;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

`include "overlay_tint_with_border_top_macros.svh"

  `OTB_NEVER(a_no_overflow, clk_i, rst_ni, push_i && status_o.full, "transfer pushed into a full queue")
  `OTB_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && status_o.empty, "pop from an empty queue")

endmodule

`default_nettype wire

// File: rtl/otb_back.sv
// Back end: overlay blend per channel, border substitution and output register.
`default_nettype none

module otb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  otb_pkg::cfg_t       cfg_i,
  input  otb_pkg::q_status_t  q_status_i,
  input  otb_pkg::pix_entry_t entry_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,
  output logic                m_axis_tlast
);
  import otb_pkg::*;

  localparam int NumCh = 3;

  // Stage 1 holds the products, the output register holds the finished pixel.
  logic                s1_valid_q;
  logic [14:0]         s1_prod_q [NumCh];
  logic                s1_hi_q, s1_border_q, s1_last_q;
  logic [PixW-1:0]     s1_alpha_q;
  logic                out_valid_q;
  logic [31:0]         out_data_q, out_data_d;
  logic                out_last_q;
  logic                adv;
  logic                hi;
  logic [PixW-1:0]     chan_c   [NumCh];
  logic [PixW-1:0]     op_c     [NumCh];
  logic [6:0]          op_l;
  logic [PixW-1:0]     blend_ch [NumCh];
  logic [14:0]         prod_d   [NumCh];

  assign adv   = !out_valid_q || m_axis_tready;
  assign pop_o = adv && !q_status_i.empty;
  assign hi    = entry_i.luminance[7];

  // Channel order is blue, green, red from the low byte up.
  always_comb begin
    // Bright pixels blend on the complements; 255-L then fits in 7 bits.
    op_l = hi ? ~entry_i.luminance[6:0] : entry_i.luminance[6:0];
    for (int i = 0; i < NumCh; i++) begin
      chan_c[i] = cfg_i.primary_color[i*PixW +: PixW];
      op_c[i]   = hi ? ~chan_c[i] : chan_c[i];
      prod_d[i] = op_c[i] * op_l;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NumCh; i++) begin
        s1_prod_q[i] <= prod_d[i];
      end
      s1_hi_q     <= hi;
      s1_border_q <= entry_i.border;
      s1_last_q   <= entry_i.frame_end;
      s1_alpha_q  <= entry_i.alpha_in;
    end
  end

  // Dark side: floor(2p/255). Bright side: 255 - ceil(2p/255).
  always_comb begin
    for (int i = 0; i < NumCh; i++) begin
      if (s1_hi_q) begin
        blend_ch[i] = 8'd255 - div255({s1_prod_q[i], 1'b0} + 16'd254);
      end else begin
        blend_ch[i] = div255({s1_prod_q[i], 1'b0});
      end
    end
    if (s1_border_q) begin
      out_data_d = {8'd255, cfg_i.border_color};
    end else begin
      out_data_d = {s1_alpha_q, blend_ch[2], blend_ch[1], blend_ch[0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
      out_last_q <= s1_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= !q_status_i.empty;
      out_valid_q <= s1_valid_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`include "overlay_tint_with_border_top_macros.svh"

  `OTB_ASSERT(a_s1_held, clk_i, rst_ni, (s1_valid_q && !adv) |=> s1_valid_q, "blend stage lost a pixel while the output stalled")

endmodule

`default_nettype wire

// File: rtl/overlay_tint_with_border_top.sv
// Top level of the overlay tint with border: register port, front, queue and back.
//
// Pixels enter on the s_axis side as luminance (tdata[7:0]) and alpha (tdata[15:8]) and leave
// on the m_axis side as blue, green, red, alpha with tlast on the last pixel of each image.
// The block takes one pixel every clock cycle while the queue is not full; the rate is set
// by the raster counters, which update in the cycle a pixel is accepted, and by the two-stage
// blend pipeline behind them. A result passes from the queue through the stage-1 register and
// then the output register. A two-entry queue between the counters and the blend pipeline
// takes in up to two input transfers while the output register holds a pixel. Registers
// (byte address): primary_color 0x00, border_color 0x04, border_enable 0x08, image_width 0x0C,
// image_height 0x10; write them only while no pixel is in flight.
`default_nettype none

module overlay_tint_with_border_top #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Pixel input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] luminance, [15:8] alpha_in
  // Pixel output.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] blue_out, [15:8] green_out, [23:16] red_out,
                                      // [31:24] alpha_out
  output logic        m_axis_tlast,   // frame_end
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import otb_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;
  logic       push, pop;
  pix_entry_t push_entry, pop_entry;
  q_status_t  q_status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.primary_color <= '0;
      cfg_q.border_color  <= '0;
      cfg_q.border_enable <= 1'b0;
      cfg_q.image_width   <= DimW'(64);
      cfg_q.image_height  <= DimW'(64);
    end else if (wr_en) begin
      case (reg_idx)
        RegPrimary: cfg_q.primary_color <= pwdata[ColorW-1:0];
        RegBorder:  cfg_q.border_color  <= pwdata[ColorW-1:0];
        RegEnable:  cfg_q.border_enable <= pwdata[0];
        RegWidth:   cfg_q.image_width   <= pwdata[DimW-1:0];
        RegHeight:  cfg_q.image_height  <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegPrimary: prdata = 32'(cfg_q.primary_color);
      RegBorder:  prdata = 32'(cfg_q.border_color);
      RegEnable:  prdata = 32'(cfg_q.border_enable);
      RegWidth:   prdata = 32'(cfg_q.image_width);
      RegHeight:  prdata = 32'(cfg_q.image_height);
      default:    prdata = '0;
    endcase
  end

  otb_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .q_status_i   (q_status),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  otb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_entry),
    .pop_i      (pop),
    .pop_data_o (pop_entry),
    .status_o   (q_status)
  );

  otb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_status_i   (q_status),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire
